// File: rtl/hrc_pkg.sv
`default_nettype none

package hrc_pkg;

  // Character codes used when decoding a record.
  localparam logic [7:0] CHAR_DIGIT_LO  = 8'h30;  // '0'
  localparam logic [7:0] CHAR_DIGIT_HI  = 8'h39;  // '9'
  localparam logic [7:0] CHAR_LETTER_LO = 8'h41;  // 'A'
  localparam logic [7:0] CHAR_LETTER_HI = 8'h5A;  // 'Z'
  localparam logic [5:0] LETTER_BASE    = 6'd10;

  // Reset value of the stop character (carriage return).
  localparam logic [7:0] STOP_CHAR_RESET = 8'd13;

  // Decoded value of one character; a letter can reach 35.
  typedef struct packed {
    logic       ok;
    logic [5:0] val;
  } char_val_t;

  function automatic char_val_t char_value(input logic [7:0] c);
    char_val_t r;
    logic [7:0] diff;
    r    = '0;
    diff = '0;
    if ((c >= CHAR_DIGIT_LO) && (c <= CHAR_DIGIT_HI)) begin
      diff  = c - CHAR_DIGIT_LO;
      r.ok  = 1'b1;
      r.val = diff[5:0];
    end else if ((c >= CHAR_LETTER_LO) && (c <= CHAR_LETTER_HI)) begin
      diff  = c - CHAR_LETTER_LO;
      r.ok  = 1'b1;
      r.val = diff[5:0] + LETTER_BASE;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// File: rtl/hrc_byte_decode.sv
`default_nettype none

module hrc_byte_decode import hrc_pkg::*; (
  input  wire logic [7:0] hi_char,
  input  wire logic [7:0] lo_char,
  output logic      [7:0] byte_val
);

  char_val_t hi_v;
  char_val_t lo_v;

  // Decode both characters of the pair.
  assign hi_v = char_value(hi_char);
  assign lo_v = char_value(lo_char);

  // Combine: high nibble shifted up, low value ORed in, kept to 8 bits.
  // An invalid character on either side gives a zero byte.
  always_comb begin
    if (hi_v.ok && lo_v.ok) begin
      byte_val = {hi_v.val[3:0], 4'b0000} | {2'b00, lo_v.val};
    end else begin
      byte_val = 8'h00;
    end
  end

endmodule

`default_nettype wire

// File: rtl/hex_record_checksum_checker.sv
// A character beat is registered on entry and its result, if any, then
// moves into the output register once that register is free or draining.
// Throughput: one character per cycle while no result is held back; the
// record state update is a single short add and compare between the input
// register and the result register. Reset (synchronous, active low) clears
// the record state and the stop character returns to carriage return (13).
`default_nettype none

module hex_record_checksum_checker import hrc_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] in_char_in,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic            out_match,
  output logic            out_empty_record,
  input  wire logic       cfg_valid,
  output logic            cfg_ready,
  input  wire logic [7:0] cfg_data
);

  logic [7:0] stop_char_r;

  logic       in_valid_r;
  logic [7:0] in_char_r;

  logic [7:0] first_char_r, first_char_nxt;
  logic       odd_phase_r, odd_phase_nxt;
  logic [7:0] byte_sum_r, byte_sum_nxt;
  logic [7:0] last_byte_r, last_byte_nxt;
  logic       have_byte_r, have_byte_nxt;

  logic       out_valid_r, out_valid_nxt;
  logic       out_match_r, out_match_nxt;
  logic       out_empty_r, out_empty_nxt;

  logic       advance;
  logic       is_stop;
  logic [7:0] pair_byte;
  logic [7:0] check_sum;

  // Configuration writes are always taken.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stop_char_r <= STOP_CHAR_RESET;
    end else if (cfg_valid) begin
      stop_char_r <= cfg_data;
    end
  end

  // The registered beat moves on when the result slot is free or draining.
  assign advance  = in_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !in_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ready) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      in_char_r <= in_char_in;
    end
  end

  hrc_byte_decode u_byte_decode (
    .hi_char  (first_char_r),
    .lo_char  (in_char_r),
    .byte_val (pair_byte)
  );

  assign is_stop   = !odd_phase_r && (in_char_r == stop_char_r);
  // The last byte matches when it cancels the running sum.
  assign check_sum = byte_sum_r + last_byte_r;

  // Record state update and result formation.
  always_comb begin
    first_char_nxt = first_char_r;
    odd_phase_nxt  = odd_phase_r;
    byte_sum_nxt   = byte_sum_r;
    last_byte_nxt  = last_byte_r;
    have_byte_nxt  = have_byte_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_match_nxt  = out_match_r;
    out_empty_nxt  = out_empty_r;
    if (advance) begin
      if (is_stop) begin
        out_valid_nxt  = 1'b1;
        out_match_nxt  = have_byte_r && (check_sum == 8'h00);
        out_empty_nxt  = !have_byte_r;
        first_char_nxt = 8'h00;
        odd_phase_nxt  = 1'b0;
        byte_sum_nxt   = 8'h00;
        last_byte_nxt  = 8'h00;
        have_byte_nxt  = 1'b0;
      end else if (!odd_phase_r) begin
        first_char_nxt = in_char_r;
        odd_phase_nxt  = 1'b1;
      end else begin
        if (have_byte_r) begin
          byte_sum_nxt = check_sum;
        end
        last_byte_nxt = pair_byte;
        have_byte_nxt = 1'b1;
        odd_phase_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_char_r <= 8'h00;
      odd_phase_r  <= 1'b0;
      byte_sum_r   <= 8'h00;
      last_byte_r  <= 8'h00;
      have_byte_r  <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      first_char_r <= first_char_nxt;
      odd_phase_r  <= odd_phase_nxt;
      byte_sum_r   <= byte_sum_nxt;
      last_byte_r  <= last_byte_nxt;
      have_byte_r  <= have_byte_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // Result payload holds while the beat waits.
  always_ff @(posedge clk) begin
    out_match_r <= out_match_nxt;
    out_empty_r <= out_empty_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_match        = out_match_r;
  assign out_empty_record = out_empty_r;

endmodule

`default_nettype wire

// File: sim/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
  import hrc_pkg::*;

  localparam int CYCLE_LIMIT   = 200000;
  localparam int SETTLE_CYCLES = 4;

  // One record verdict as the checker reports it.
  typedef struct packed {
    logic match;
    logic empty_record;
  } verdict_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] in_char_in = 8'h00;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic       out_match;
  logic       out_empty_record;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [7:0] cfg_data = 8'h00;

  // Expected record verdicts, oldest first.
  verdict_t expected_verdicts[$];

  // Shadow copy of the record state and the stop character.
  logic [7:0] stop_model = STOP_CHAR_RESET;
  logic [7:0] rec_first = 8'h00;
  logic       rec_odd = 1'b0;
  logic [7:0] rec_sum = 8'h00;
  logic [7:0] rec_last = 8'h00;
  logic       rec_have = 1'b0;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int error_count = 0;
  int chars_sent = 0;
  int records_seen = 0;
  int matches_seen = 0;
  int empties_seen = 0;
  int stop_writes = 0;
  int cycle_count = 0;

  hex_record_checksum_checker dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_char_in       (in_char_in),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_match        (out_match),
    .out_empty_record (out_empty_record),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_data         (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d verdicts pending.", cycle_count,
               expected_verdicts.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Result side backpressure.
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  task automatic report_mismatch(input string what, input int want, input int got);
    $display("MISMATCH %s: expected %0d, got %0d (cycle %0d)", what, want, got, cycle_count);
    error_count++;
  endtask

  // Compare every result beat with the oldest expected verdict.
  always @(posedge clk) begin
    verdict_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_verdicts.size() == 0) begin
        report_mismatch("unexpected result beat", 0, 1);
      end else begin
        want = expected_verdicts.pop_front();
        records_seen++;
        if (out_match) matches_seen++;
        if (out_empty_record) empties_seen++;
        if (out_match !== want.match)
          report_mismatch("match", want.match, out_match);
        if (out_empty_record !== want.empty_record)
          report_mismatch("empty_record", want.empty_record, out_empty_record);
      end
    end
  end

  // Weight of a single character; ok is low for anything but 0-9 and A-Z.
  function automatic logic [9:0] char_weight(input logic [7:0] c, output bit ok);
    ok = 1'b1;
    if (c >= CHAR_DIGIT_LO && c <= CHAR_DIGIT_HI) begin
      return {2'b00, c} - {2'b00, CHAR_DIGIT_LO};
    end else if (c >= CHAR_LETTER_LO && c <= CHAR_LETTER_HI) begin
      return {2'b00, c} - {2'b00, CHAR_LETTER_LO} + {4'd0, LETTER_BASE};
    end
    ok = 1'b0;
    return 10'd0;
  endfunction

  function automatic logic [7:0] pair_value(input logic [7:0] hi, input logic [7:0] lo);
    logic [9:0] w_hi;
    logic [9:0] w_lo;
    logic [9:0] full;
    bit ok_hi;
    bit ok_lo;
    w_hi = char_weight(hi, ok_hi);
    w_lo = char_weight(lo, ok_lo);
    full = (w_hi << 4) | w_lo;
    return (ok_hi && ok_lo) ? full[7:0] : 8'h00;
  endfunction

  function automatic logic [7:0] hex_digit(input logic [3:0] n);
    if (n < 4'd10) return CHAR_DIGIT_LO + {4'd0, n};
    return CHAR_LETTER_LO + {4'd0, n} - {2'b00, LETTER_BASE};
  endfunction

  // Advance the shadow record state by one accepted character.
  task automatic track_char(input logic [7:0] c);
    verdict_t v;
    if (!rec_odd) begin
      if (c == stop_model) begin
        if (rec_have) begin
          v.match        = (rec_last == 8'h00 - rec_sum);
          v.empty_record = 1'b0;
        end else begin
          v.match        = 1'b0;
          v.empty_record = 1'b1;
        end
        expected_verdicts.push_back(v);
        rec_first = 8'h00;
        rec_odd   = 1'b0;
        rec_sum   = 8'h00;
        rec_last  = 8'h00;
        rec_have  = 1'b0;
      end else begin
        rec_first = c;
        rec_odd   = 1'b1;
      end
    end else begin
      if (rec_have) rec_sum = rec_sum + rec_last;
      rec_last = pair_value(rec_first, c);
      rec_have = 1'b1;
      rec_odd  = 1'b0;
    end
  endtask

  // Send one character beat, with random idle cycles ahead of it.
  task automatic send_char(input logic [7:0] c);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_char_in <= c;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    track_char(c);
    chars_sent++;
  endtask

  // Hold the input off until every expected verdict has come back.
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_verdicts.size() != 0) @(posedge clk);
  endtask

  task automatic write_stop_char(input logic [7:0] v);
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    stop_model = v;
    stop_writes++;
  endtask

  // Mostly well-formed records with a correct checksum byte; the rest are
  // damaged records, random noise, odd lengths and empty records.
  task automatic send_random_record();
    int kind;
    int nbytes;
    int bad_at;
    int k;
    int len;
    logic [7:0] b;
    logic [7:0] sum;
    logic [7:0] c;
    kind = $urandom_range(99);
    if (kind < 80) begin
      nbytes = $urandom_range(8);
      bad_at = (kind >= 70) ? $urandom_range(2 * nbytes + 1) : -1;
      sum = 8'h00;
      k = 0;
      for (int i = 0; i <= nbytes; i++) begin
        b = (i == nbytes) ? 8'h00 - sum : 8'($urandom_range(255));
        sum = sum + b;
        c = hex_digit(b[7:4]);
        if (k == bad_at) c = 8'($urandom_range(255));
        send_char(c);
        k++;
        c = hex_digit(b[3:0]);
        if (k == bad_at) c = 8'($urandom_range(255));
        send_char(c);
        k++;
      end
    end else if (kind < 93) begin
      len = $urandom_range(12, 1);
      for (int i = 0; i < len; i++) begin
        case ($urandom_range(5))
          0: c = stop_model;
          1, 2: c = 8'($urandom_range(CHAR_LETTER_HI, CHAR_DIGIT_LO));
          default: c = 8'($urandom_range(255));
        endcase
        send_char(c);
      end
    end
    send_char(stop_model);
  endtask

  task automatic test_basic_records();
    send_char(stop_model);
    send_char("0");
    send_char("0");
    send_char(stop_model);
    send_char("F");
    send_char("F");
    send_char("0");
    send_char("1");
    send_char(stop_model);
  endtask

  task automatic test_special_pairs();
    // Stop character in the second slot of a pair is plain data.
    send_char("1");
    send_char(stop_model);
    send_char(stop_model);
    // Letters above F, in the high and in the low slot.
    send_char("Z");
    send_char("0");
    send_char("0");
    send_char("Z");
    send_char(stop_model);
    // Extreme codes and characters just outside the digit and letter ranges.
    send_char(8'h00);
    send_char(8'hFF);
    send_char(stop_model);
    send_char("/");
    send_char("@");
    send_char("[");
    send_char("9");
    send_char(stop_model);
  endtask

  task automatic test_stop_char_sweep();
    logic [7:0] settings[4];
    int start;
    settings[0] = 8'h00;
    settings[1] = 8'hFF;
    settings[2] = hex_digit(4'($urandom_range(15)));
    settings[3] = 8'($urandom_range(255));
    send_idle_pct = 25;
    recv_idle_pct = 49;
    foreach (settings[s]) begin
      write_stop_char(settings[s]);
      start = chars_sent;
      while (chars_sent - start < 25) send_random_record();
    end
  endtask

  task automatic test_random_traffic(input int send_pct, input int recv_pct,
                                     input logic [7:0] stop, input int budget);
    int start;
    bit paused;
    write_stop_char(stop);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    start = chars_sent;
    paused = 1'b0;
    while (chars_sent - start < budget) begin
      if (!paused && chars_sent - start >= budget / 2) begin
        wait_drained();
        paused = 1'b1;
      end
      send_random_record();
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_basic_records();
    test_special_pairs();
    test_stop_char_sweep();
    test_random_traffic(25, 49, STOP_CHAR_RESET, 160);
    test_random_traffic(49, 25, ":", 160);
    test_random_traffic(0, 0, 8'($urandom_range(255)), 160);

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Run covered %0d characters, %0d record verdicts (%0d matching, %0d empty).",
             chars_sent, records_seen, matches_seen, empties_seen);
    $display("Stop character rewritten %0d times; three idle mixes on both channels.",
             stop_writes);
    if (error_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("%0d mismatches found.", error_count);
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// File: hex_record_checksum_checker.f
rtl/hrc_pkg.sv
rtl/hrc_byte_decode.sv
rtl/hex_record_checksum_checker.sv
sim/tb_top.sv
